/* sv/pqtda_pkg.sv */
// Shared constants and codes for the product-quantization distance accumulator.
package pqtda_pkg;

    // Default and upper bound for the number of code bytes, one table bank each.
    localparam int MAX_CODE_BYTES_DEF = 8;
    // Width of the adder tree.
    localparam int TREE_LANES         = 8;
    // Entries in each per-byte sub-table.
    localparam int CODES_PER_TABLE    = 256;
    localparam int CODE_W             = 8;
    localparam int SLOT_W             = 3;
    localparam int Q_W                = 32;
    localparam int CFG_W              = 4;
    // Packed input payload: 139 field bits padded to whole bytes.
    localparam int S_TDATA_W          = 144;
    localparam int M_TDATA_W          = 32;

    // Partial sum widths through the adder tree.
    localparam int PAIR_W             = Q_W + 1;
    localparam int QUAD_W             = Q_W + 2;
    localparam int OCT_W              = Q_W + 3;
    localparam int SUM_W              = Q_W + 4;

    // Reset value of the bytes-in-use register.
    localparam logic [CFG_W-1:0] BYTES_IN_USE_RST = 4'd8;

    // Item kinds carried on the input tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

endpackage

/* sv/pqtda_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read port.
module pqtda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/pq_table_distance_accumulate.sv */
// Top level: product-quantization table lookup and distance accumulation pipeline.
// A score transfer passes through the registered table read with stage 1, the three
// adder-tree levels and saturation into the output register.
// Throughput: one item per cycle unless the output stalls; each bank gives one read per cycle.
// Reset: rst_n clears the stage valid bits and sets bytes_in_use to 8; the table
// contents are undefined until written by load transfers.
module pq_table_distance_accumulate
    import pqtda_pkg::*;
#(
    parameter int MAX_CODE_BYTES = MAX_CODE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write channel: bytes_in_use.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0 up: table_slot[2:0], table_code[10:3], table_value[42:11],
    // start_distance[74:43], codes[138:75], zero padding[143:139].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode (0 loads a table entry, 1 scores one point).
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0 up: distance[31:0].
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // tuser: saturated.
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int ADDR_W = $clog2(CODES_PER_TABLE);

    // Input field unpacking.
    logic [SLOT_W-1:0]       in_slot;
    logic [CODE_W-1:0]       in_code;
    logic [Q_W-1:0]          in_value;
    logic [Q_W-1:0]          in_start;
    logic [TREE_LANES*CODE_W-1:0] in_codes;

    assign in_slot  = s_axis_tdata[2:0];
    assign in_code  = s_axis_tdata[10:3];
    assign in_value = s_axis_tdata[42:11];
    assign in_start = s_axis_tdata[74:43];
    assign in_codes = s_axis_tdata[138:75];

    // The configuration register may be written at any time the block is idle.
    logic [CFG_W-1:0] bytes_reg;
    logic [CFG_W-1:0] eff_bytes;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= BYTES_IN_USE_RST;
        end
        else if (cfg_valid)
        begin
            bytes_reg <= cfg_data;
        end
    end

    // Values above the number of banks clamp to the number of banks.
    assign eff_bytes = (bytes_reg > CFG_W'(MAX_CODE_BYTES)) ? CFG_W'(MAX_CODE_BYTES)
                                                           : bytes_reg;

    // Stage handshake. Each stage loads when it is empty or its successor loads, so
    // bubbles are squeezed out and a stalled output never drops or repeats a result.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic in_xfer;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Table banks: one bank per code byte position. A load transfer writes the bank
    // named by its slot; a slot beyond the banks writes nothing. Every bank is read
    // with the matching code byte whenever stage 1 loads, so the read data stays
    // aligned with stage 1 through a stall. A load followed by a score of the same
    // entry reads the new value, since the write lands at the load's transfer edge.
    logic [Q_W-1:0] lane_data [TREE_LANES];

    for (genvar k = 0; k < TREE_LANES; k++)
    begin : g_bank
        if (k < MAX_CODE_BYTES)
        begin : g_mem
            logic bank_we;

            assign bank_we = in_xfer && (s_axis_tuser == OP_LOAD)
                             && (in_slot == SLOT_W'(k));

            pqtda_ram #(
                .WIDTH (Q_W),
                .DEPTH (CODES_PER_TABLE)
            ) u_bank (
                .clk     (clk),
                .wr_en   (bank_we),
                .wr_addr (in_code[ADDR_W-1:0]),
                .wr_data (in_value),
                .rd_en   (en1),
                .rd_addr (in_codes[k*CODE_W +: ADDR_W]),
                .rd_data (lane_data[k])
            );
        end
        else
        begin : g_none
            assign lane_data[k] = '0;
        end
    end

    // Stage 1: score items only; lane mask from the bytes in use.
    logic [TREE_LANES-1:0] mask1_reg,  mask1_next;
    logic [Q_W-1:0]        start1_reg;
    logic                  last1_reg;

    always_comb
    begin
        for (int k = 0; k < TREE_LANES; k++)
        begin
            mask1_next[k] = (CFG_W'(k) < eff_bytes);
        end
    end

    // Stage 2: pair sums of the selected entries.
    logic signed [PAIR_W-1:0] pair2_reg [TREE_LANES/2];
    logic signed [PAIR_W-1:0] pair2_next [TREE_LANES/2];
    logic [Q_W-1:0]           start2_reg;
    logic                     last2_reg;

    always_comb
    begin
        logic signed [Q_W-1:0] ea;
        logic signed [Q_W-1:0] eb;
        for (int p = 0; p < TREE_LANES/2; p++)
        begin
            ea = mask1_reg[2*p]   ? $signed(lane_data[2*p])   : '0;
            eb = mask1_reg[2*p+1] ? $signed(lane_data[2*p+1]) : '0;
            pair2_next[p] = PAIR_W'(ea) + PAIR_W'(eb);
        end
    end

    // Stage 3: quad sums.
    logic signed [QUAD_W-1:0] quad3_reg [TREE_LANES/4];
    logic signed [QUAD_W-1:0] quad3_next [TREE_LANES/4];
    logic [Q_W-1:0]           start3_reg;
    logic                     last3_reg;

    always_comb
    begin
        for (int p = 0; p < TREE_LANES/4; p++)
        begin
            quad3_next[p] = QUAD_W'(pair2_reg[2*p]) + QUAD_W'(pair2_reg[2*p+1]);
        end
    end

    // Stage 4: full sum of the entries plus the start distance. It cannot overflow
    // SUM_W bits, so the saturation test afterward is exact.
    logic signed [SUM_W-1:0] sum4_reg, sum4_next;
    logic                    last4_reg;
    logic signed [OCT_W-1:0] oct_sum;

    assign oct_sum   = OCT_W'(quad3_reg[0]) + OCT_W'(quad3_reg[1]);
    assign sum4_next = SUM_W'(oct_sum) + SUM_W'($signed(start3_reg));

    // Stage 5: saturate to the signed Q16.16 range into the output register.
    logic [Q_W-1:0] dist5_reg, dist5_next;
    logic           sat5_reg,  sat5_next;
    logic           last5_reg;

    always_comb
    begin
        // In range exactly when the bits above the 32-bit sign all match it.
        if (sum4_reg[SUM_W-1:Q_W-1] == '0 || sum4_reg[SUM_W-1:Q_W-1] == '1)
        begin
            dist5_next = sum4_reg[Q_W-1:0];
            sat5_next  = 1'b0;
        end
        else if (sum4_reg[SUM_W-1])
        begin
            dist5_next = {1'b1, {(Q_W-1){1'b0}}};
            sat5_next  = 1'b1;
        end
        else
        begin
            dist5_next = {1'b0, {(Q_W-1){1'b1}}};
            sat5_next  = 1'b1;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_xfer && (s_axis_tuser == OP_SCORE);
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mask1_reg  <= mask1_next;
            start1_reg <= in_start;
            last1_reg  <= s_axis_tlast;
        end
        if (en2)
        begin
            pair2_reg  <= pair2_next;
            start2_reg <= start1_reg;
            last2_reg  <= last1_reg;
        end
        if (en3)
        begin
            quad3_reg  <= quad3_next;
            start3_reg <= start2_reg;
            last3_reg  <= last2_reg;
        end
        if (en4)
        begin
            sum4_reg   <= sum4_next;
            last4_reg  <= last3_reg;
        end
        if (en5)
        begin
            dist5_reg  <= dist5_next;
            sat5_reg   <= sat5_next;
            last5_reg  <= last4_reg;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = dist5_reg;
    assign m_axis_tuser  = sat5_reg;
    assign m_axis_tlast  = last5_reg;

endmodule
